/* rtl/pidl_pkg.sv */
package pidl_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_WRITE  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NOKEY = 2'd3
  } status_e;

  // per-cell control, decoded at the top level from the accepted item
  typedef struct packed {
    logic valid;       // cell index lies below the fill count
    logic load_new;    // take the new pair
    logic take_lower;  // shift up: take the pair of the cell below
    logic take_upper;  // shift down: take the pair of the cell above
    logic key_write;   // write-by-key item in progress
  } cell_ctrl_t;

endpackage

/* rtl/pidl_cell.sv */
module pidl_cell (
  input  logic                                clk_i,
  input  pidl_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [pidl_pkg::KEY_W-1:0]   new_key_i,
  input  logic signed [pidl_pkg::VAL_W-1:0]   new_value_i,
  input  logic signed [pidl_pkg::KEY_W-1:0]   lo_key_i,
  input  logic signed [pidl_pkg::VAL_W-1:0]   lo_value_i,
  input  logic signed [pidl_pkg::KEY_W-1:0]   hi_key_i,
  input  logic signed [pidl_pkg::VAL_W-1:0]   hi_value_i,
  input  logic                                found_i,
  input  logic signed [pidl_pkg::VAL_W-1:0]   rd_i,
  output logic signed [pidl_pkg::KEY_W-1:0]   key_o,
  output logic signed [pidl_pkg::VAL_W-1:0]   value_o,
  output logic                                found_o,
  output logic signed [pidl_pkg::VAL_W-1:0]   rd_o
);
  import pidl_pkg::*;

  logic signed [KEY_W-1:0] key_q, key_d;
  logic signed [VAL_W-1:0] value_q, value_d;
  logic                    match;
  logic                    hit;

  // first valid match along the chain wins
  assign match   = ctrl_i.valid && (key_q == new_key_i);
  assign hit     = match && !found_i;
  assign found_o = found_i || match;
  assign rd_o    = rd_i | (hit ? value_q : '0);

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.load_new) begin
      key_d   = new_key_i;
      value_d = new_value_i;
    end else if (ctrl_i.take_lower) begin
      key_d   = lo_key_i;
      value_d = lo_value_i;
    end else if (ctrl_i.take_upper) begin
      key_d   = hi_key_i;
      value_d = hi_value_i;
    end else if (ctrl_i.key_write && hit) begin
      value_d = new_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

/* rtl/positional_insert_delete_list.sv */
// Channel  Direction  Accepted when                  Payload
// s_axis   in         s_axis_tvalid_i & tready_o     operation, position, key, value
// m_axis   out        m_axis_tvalid_o & tready_i     status, read_value, entry_count
//
// One item per cycle while not stalled: every cell shifts, loads or compares
// in the same cycle; the result is registered in the cycle after acceptance.
// The key search ripples a found flag through the row of cells.
// Reset clears the fill count and the output valid; entry contents are kept.
// A stalled result holds the output register; input is taken only while the
// register is empty or being emptied.
module positional_insert_delete_list #(
  parameter int CAPACITY = pidl_pkg::CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // operation[1:0], position[5:2], key[37:6], value[69:38], zero[71:70]
  input  logic [71:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[1:0], read_value[33:2], entry_count[38:34], zero[39]
  output logic [39:0] m_axis_tdata_o
);
  import pidl_pkg::*;

  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;

  op_e                     op;
  logic [POS_W-1:0]        pos;
  logic signed [KEY_W-1:0] in_key;
  logic signed [VAL_W-1:0] in_value;

  assign op       = op_e'(s_axis_tdata_i[1:0]);
  assign pos      = s_axis_tdata_i[5:2];
  assign in_key   = s_axis_tdata_i[37:6];
  assign in_value = s_axis_tdata_i[69:38];

  logic [CNTW-1:0] count_q, count_d;
  logic            out_valid_q;
  status_e         status_q, status_d;
  logic signed [VAL_W-1:0]   rd_q, rd_d;
  logic [COUNT_W-1:0]        cnt_out_q;

  logic            fire;
  logic [CMPW-1:0] pos_ext, count_ext, at;
  logic            full, ins_ok, rem_ok, is_ins, is_rem, is_write;
  logic [31:0]     count_wide;

  logic signed [KEY_W-1:0] keys   [CAPACITY];
  logic signed [VAL_W-1:0] values [CAPACITY];
  logic                    found_c [CAPACITY+1];
  logic signed [VAL_W-1:0] rd_c    [CAPACITY+1];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign fire            = s_axis_tvalid_i && s_axis_tready_o;

  assign pos_ext   = CMPW'(pos);
  assign count_ext = CMPW'(count_q);
  assign full      = (count_ext == CMPW'(CAPACITY));
  assign is_ins    = fire && (op == OP_INSERT);
  assign is_rem    = fire && (op == OP_REMOVE);
  assign is_write  = fire && (op == OP_WRITE);
  assign ins_ok    = is_ins && !full && (pos_ext <= count_ext);
  assign rem_ok    = is_rem && (pos_ext < count_ext);
  // position zero appends
  assign at        = (pos == '0) ? count_ext : pos_ext;

  assign found_c[0] = 1'b0;
  assign rd_c[0]    = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CMPW-1:0] IDX = CMPW'(i);
    cell_ctrl_t              ctrl;
    logic signed [KEY_W-1:0] lo_key, hi_key;
    logic signed [VAL_W-1:0] lo_value, hi_value;

    assign ctrl.valid      = IDX < count_ext;
    assign ctrl.load_new   = ins_ok && (IDX == at);
    assign ctrl.take_lower = ins_ok && (IDX > at) && (IDX <= count_ext);
    assign ctrl.take_upper = rem_ok && (IDX >= pos_ext) && ((IDX + 1'b1) < count_ext);
    assign ctrl.key_write  = is_write;

    if (i == 0) begin : g_lo_edge
      assign lo_key   = '0;
      assign lo_value = '0;
    end else begin : g_lo
      assign lo_key   = keys[i-1];
      assign lo_value = values[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hi_edge
      assign hi_key   = '0;
      assign hi_value = '0;
    end else begin : g_hi
      assign hi_key   = keys[i+1];
      assign hi_value = values[i+1];
    end

    pidl_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_key_i   (in_key),
      .new_value_i (in_value),
      .lo_key_i    (lo_key),
      .lo_value_i  (lo_value),
      .hi_key_i    (hi_key),
      .hi_value_i  (hi_value),
      .found_i     (found_c[i]),
      .rd_i        (rd_c[i]),
      .key_o       (keys[i]),
      .value_o     (values[i]),
      .found_o     (found_c[i+1]),
      .rd_o        (rd_c[i+1])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_OK;
    rd_d     = '0;
    if (ins_ok) begin
      count_d = count_q + 1'b1;
    end else if (rem_ok) begin
      count_d = count_q - 1'b1;
    end
    case (op)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (pos_ext > count_ext) begin
          status_d = ST_RANGE;
        end
      end
      OP_REMOVE: begin
        if (pos_ext >= count_ext) begin
          status_d = ST_RANGE;
        end
      end
      OP_READ: begin
        if (found_c[CAPACITY]) begin
          rd_d = rd_c[CAPACITY];
        end else begin
          status_d = ST_NOKEY;
        end
      end
      OP_WRITE: begin
        if (!found_c[CAPACITY]) begin
          status_d = ST_NOKEY;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  assign count_wide = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result while the far side stalls
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= status_d;
      rd_q      <= rd_d;
      cnt_out_q <= count_wide[COUNT_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, cnt_out_q, rd_q, status_q};

endmodule
